// ===== sv/tgcc_pkg.sv =====
// tgcc_pkg: shared widths, command/result beat structs, codes and the cleared
// feature state for the tile geometry command classifier.
// No dependencies; imported by tgcc_step and tile_geometry_command_classifier.
package tgcc_pkg;

    // widths
    localparam int COORD_BITS  = 16;
    localparam int AREA_BITS   = 48;
    localparam int EXT_BITS    = 15;
    localparam int RES_AREA_W  = 48;
    localparam int PROD_W      = 2 * COORD_BITS;
    localparam int CMP_W       = (COORD_BITS > EXT_BITS ? COORD_BITS : EXT_BITS) + 1;

    // tile extent after reset
    localparam logic [EXT_BITS-1:0] EXTENT_RESET = EXT_BITS'(4096);

    // command codes
    localparam logic [1:0] ACT_MOVETO    = 2'd0;
    localparam logic [1:0] ACT_LINETO    = 2'd1;
    localparam logic [1:0] ACT_CLOSE     = 2'd2;
    localparam logic [1:0] ACT_CLOSE_ALT = 2'd3;

    // geometry types
    localparam logic [1:0] GEOM_UNKNOWN = 2'd0;
    localparam logic [1:0] GEOM_POINT   = 2'd1;
    localparam logic [1:0] GEOM_LINE    = 2'd2;
    localparam logic [1:0] GEOM_POLYGON = 2'd3;

    // feature kinds
    localparam logic [2:0] KIND_POINT        = 3'd0;
    localparam logic [2:0] KIND_MULTIPOINT   = 3'd1;
    localparam logic [2:0] KIND_LINE         = 3'd2;
    localparam logic [2:0] KIND_MULTILINE    = 3'd3;
    localparam logic [2:0] KIND_POLYGON      = 3'd4;
    localparam logic [2:0] KIND_MULTIPOLYGON = 3'd5;
    localparam logic [2:0] KIND_EMPTY        = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED    = 2'd1;
    localparam logic [1:0] ERR_INNER_FIRST = 2'd2;

    // edge flag bit positions
    localparam int FLAG_WEST  = 0;
    localparam int FLAG_EAST  = 1;
    localparam int FLAG_NORTH = 2;
    localparam int FLAG_SOUTH = 3;

    // saturation point of the small counters
    localparam logic [1:0] CNT_SAT = 2'd2;

    // one command beat
    typedef struct packed {
        logic [1:0]                   action;
        logic [1:0]                   geom_type;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic [3:0]                   vertex_flags;
        logic [3:0]                   feature_flags;
        logic                         ring_done;
        logic signed [RES_AREA_W-1:0] ring_double_area;
        logic                         ring_is_outer;
        logic                         new_polygon;
        logic [2:0]                   feature_kind;
        logic [1:0]                   error_code;
        logic                         result_last;
    } t_res;

    // per-feature state
    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] prev_x;
        logic signed [COORD_BITS-1:0] prev_y;
        logic [AREA_BITS-1:0]         area;
        logic [1:0]                   ring_count;
        logic [1:0]                   outer_count;
        logic [1:0]                   moveto_count;
        logic [1:0]                   command_count;
        logic [3:0]                   flags;
        logic                         prev_close;
        logic [1:0]                   err;
    } t_state;

    // state at reset and after the last command of a feature
    localparam t_state ST_CLEAR = '{prev_close: 1'b1, default: '0};

endpackage

// ===== sv/tgcc_step.sv =====
// tgcc_step: combinational update for one command beat: edge flags, shoelace
// cross product and accumulate, ring classification, errors and feature kind.
// Depends on tgcc_pkg.
module tgcc_step
    import tgcc_pkg::*;
(
    input  t_state              i_state,
    input  t_cmd                i_cmd,
    input  logic [EXT_BITS-1:0] i_extent,
    output t_state              o_state,
    output t_res                o_res
);

    // flags of a vertex against the tile box
    function automatic logic [3:0] edge_flags(
        input logic signed [COORD_BITS-1:0] vx,
        input logic signed [COORD_BITS-1:0] vy,
        input logic [EXT_BITS-1:0]          ext
    );
        logic signed [CMP_W-1:0] xs;
        logic signed [CMP_W-1:0] ys;
        logic signed [CMP_W-1:0] es;
        logic [3:0]              f;
        xs = CMP_W'(vx);
        ys = CMP_W'(vy);
        es = $signed(CMP_W'(ext));
        f  = '0;
        if (vx[COORD_BITS-1]) begin
            f[FLAG_WEST] = 1'b1;
        end else if (xs >= es) begin
            f[FLAG_EAST] = 1'b1;
        end
        if (vy[COORD_BITS-1]) begin
            f[FLAG_NORTH] = 1'b1;
        end else if (ys >= es) begin
            f[FLAG_SOUTH] = 1'b1;
        end
        return f;
    endfunction

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        return (c >= CNT_SAT) ? CNT_SAT : c + 2'd1;
    endfunction

    logic [1:0]                   act;
    logic                         is_close;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [PROD_W-1:0]     prod_p;
    logic signed [PROD_W-1:0]     prod_q;
    logic [AREA_BITS-1:0]         p_ext;
    logic [AREA_BITS-1:0]         q_ext;
    logic [AREA_BITS-1:0]         area_sum;
    logic [3:0]                   vtx_flags;

    // closepath aliases and the (0,0) vertex it stands for
    assign act      = (i_cmd.action == ACT_CLOSE_ALT) ? ACT_CLOSE : i_cmd.action;
    assign is_close = (act == ACT_CLOSE);
    assign vx       = is_close ? '0 : i_cmd.x;
    assign vy       = is_close ? '0 : i_cmd.y;

    // cross product of the previous vertex with the new one, or the ring start
    assign bx       = (act == ACT_LINETO) ? i_cmd.x : i_state.first_x;
    assign by       = (act == ACT_LINETO) ? i_cmd.y : i_state.first_y;
    assign prod_p   = i_state.prev_x * by;
    assign prod_q   = i_state.prev_y * bx;
    assign p_ext    = AREA_BITS'(prod_p);
    assign q_ext    = AREA_BITS'(prod_q);
    assign area_sum = i_state.area + p_ext - q_ext;

    assign vtx_flags = edge_flags(vx, vy, i_extent);

    // state update and result
    always_comb begin
        t_state st;
        t_res   res;
        logic   first_ring;
        logic   nonneg;
        st         = i_state;
        res        = '0;
        first_ring = (i_state.ring_count == 2'd1);
        nonneg     = ~area_sum[AREA_BITS-1];

        case (i_cmd.geom_type) inside
            GEOM_POINT, GEOM_LINE: begin
                res.vertex_flags = vtx_flags;
                st.command_count = sat_inc(i_state.command_count);
                if (act == ACT_MOVETO) begin
                    st.moveto_count = sat_inc(i_state.moveto_count);
                end
            end
            GEOM_POLYGON: begin
                if (act == ACT_MOVETO) begin
                    if (!i_state.prev_close) begin
                        st.err = ERR_UNCLOSED;
                    end
                    st.ring_count    = sat_inc(i_state.ring_count);
                    st.area          = '0;
                    st.first_x       = i_cmd.x;
                    st.first_y       = i_cmd.y;
                    st.prev_x        = i_cmd.x;
                    st.prev_y        = i_cmd.y;
                    res.vertex_flags = vtx_flags;
                end else if (i_state.ring_count != 2'd0 && act == ACT_LINETO) begin
                    st.area          = area_sum;
                    st.prev_x        = i_cmd.x;
                    st.prev_y        = i_cmd.y;
                    res.vertex_flags = vtx_flags;
                end else if (i_state.ring_count != 2'd0) begin
                    st.area   = area_sum;
                    st.prev_x = i_state.first_x;
                    st.prev_y = i_state.first_y;
                    // ring report, not for a repeated closepath
                    if (!i_state.prev_close) begin
                        res.ring_done        = 1'b1;
                        res.ring_double_area = RES_AREA_W'(area_sum);
                        res.ring_is_outer    = nonneg | first_ring;
                        res.new_polygon      = nonneg & ~first_ring;
                        if (first_ring && !nonneg && st.err == ERR_NONE) begin
                            st.err = ERR_INNER_FIRST;
                        end
                        if (nonneg || first_ring) begin
                            st.outer_count = sat_inc(i_state.outer_count);
                        end
                    end
                end
                st.prev_close = is_close;
                if (i_cmd.last && !is_close) begin
                    st.err = ERR_UNCLOSED;
                end
            end
            default: begin
            end
        endcase

        st.flags = st.flags | res.vertex_flags;

        // feature kind on the last command
        if (i_cmd.last) begin
            case (i_cmd.geom_type)
                GEOM_POINT:   res.feature_kind = (st.command_count == 2'd1) ?
                                                 KIND_POINT : KIND_MULTIPOINT;
                GEOM_LINE:    res.feature_kind = (st.moveto_count < CNT_SAT) ?
                                                 KIND_LINE : KIND_MULTILINE;
                GEOM_POLYGON: res.feature_kind = (st.ring_count == 2'd0) ? KIND_EMPTY :
                                                 (st.outer_count > 2'd1) ?
                                                 KIND_MULTIPOLYGON : KIND_POLYGON;
                default:      res.feature_kind = KIND_EMPTY;
            endcase
        end

        res.feature_flags = (i_cmd.geom_type == GEOM_UNKNOWN) ? 4'd0 : st.flags;
        res.error_code    = st.err;
        res.result_last   = i_cmd.last;

        o_res   = res;
        o_state = i_cmd.last ? ST_CLEAR : st;
    end

endmodule

// ===== sv/tile_geometry_command_classifier.sv =====
// tile_geometry_command_classifier: top level; command input register, feature
// state, tile extent register and result register around tgcc_step.
// Depends on tgcc_pkg and tgcc_step.
//
//  channel  | direction | handshake               | beat
//  ---------+-----------+-------------------------+--------------------------
//  command  | in        | i_in_valid / o_in_ready | t_cmd, one geometry command
//  result   | out       | o_out_valid/i_out_ready | t_res, one per command
//  config   | in        | i_cfg_valid/o_cfg_ready | tile extent, 15 bits
//
// One command per cycle while the result side accepts; a result is offered once its
// command has passed the input register, then the result register, with the cross
// product and 48-bit accumulate in tgcc_step combinational between the two.
// Synchronous reset restores extent 4096 and the cleared feature state.
// A stalled result holds in the result register while the next command waits
// in the input register; ready falls only when both are full and stalled.
module tile_geometry_command_classifier
    import tgcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_cmd                i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_res                o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [EXT_BITS-1:0] i_cfg_data
);

    logic                r_in_vld;
    logic                n_in_vld;
    t_cmd                r_in;
    logic                r_out_vld;
    logic                n_out_vld;
    t_res                r_out;
    t_res                n_out;
    t_state              r_state;
    t_state              n_state;
    logic [EXT_BITS-1:0] r_extent;
    logic                advance;
    logic                in_take;

    // pipeline handshake
    assign advance    = r_in_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready = ~r_in_vld | advance;
    assign in_take    = i_in_valid & o_in_ready;
    assign n_in_vld   = in_take | (r_in_vld & ~advance);
    assign n_out_vld  = advance | (r_out_vld & ~i_out_ready);

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // per-command update
    tgcc_step u_step (
        .i_state  (r_state),
        .i_cmd    (r_in),
        .i_extent (r_extent),
        .o_state  (n_state),
        .o_res    (n_out)
    );

    // control and feature state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= ST_CLEAR;
            r_extent  <= EXTENT_RESET;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_extent <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // held command is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in))
        else $error("held command changed while stalled");

    // feature state is cleared after the last command
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last |=> r_state == ST_CLEAR)
        else $error("feature state not cleared after last command");

    // ring fields are zero unless a ring is reported
    a_ring_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ring_done |->
            o_out_data.ring_double_area == '0 && !o_out_data.ring_is_outer &&
            !o_out_data.new_polygon)
        else $error("ring fields set without ring");

    // a new polygon part is always an outer ring
    a_new_outer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.new_polygon |-> o_out_data.ring_is_outer)
        else $error("new polygon on inner ring");

    // kind only on the last result
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_last |-> o_out_data.feature_kind == KIND_POINT)
        else $error("feature kind outside last result");

endmodule
